### hdl/aesrs_pkg.sv
// ----------------------------------------------------------------------------
// AES round step package
// Shared block type, action codes and the forward and inverse S-box tables.
// ----------------------------------------------------------------------------
package aesrs_pkg;

  // Sixteen state bytes, byte 0 in the most significant position.
  typedef logic [0:15][7:0] block_t;

  typedef enum logic [2:0] {
    ACT_ADDKEY     = 3'd0,
    ACT_SUB        = 3'd1,
    ACT_INVSUB     = 3'd2,
    ACT_SHIFT      = 3'd3,
    ACT_INVSHIFT   = 3'd4,
    ACT_MIX        = 3'd5,
    ACT_INVMIX     = 3'd6
  } action_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

endpackage

### hdl/aes_round_step_unit.sv
// ----------------------------------------------------------------------------
// AES round step unit
// Applies one AES-128 round transformation to a 128-bit state per request.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock cycle while the output is not
// stalled. Each request passes first through the input register and then the
// result register, with the S-box lookups, row shifts and column mixing done
// in the logic between them. Both registers advance whenever the result
// register is empty or being drained, so a stalled output still lets a
// request enter the empty input register. The code 7 in the action field
// returns the state unchanged, and the key matters only to AddRoundKey.
module aes_round_step_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // state_hi, state_lo, key_hi, key_lo
  input  logic [2:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_hi, result_lo
);

  logic               in_valid;
  aesrs_pkg::action_t in_action;
  aesrs_pkg::block_t  in_state;
  aesrs_pkg::block_t  in_key;
  aesrs_pkg::block_t  result;
  aesrs_pkg::block_t  out_block;
  logic               out_valid;
  logic               out_advance;
  logic               in_take;

  assign out_advance   = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_take || (in_valid && !out_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action <= aesrs_pkg::action_t'(s_axis_tuser);
      in_state  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      in_key    <= {s_axis_tdata[191:128], s_axis_tdata[255:192]};
    end
  end

  aesrs_round_logic u_round (
    .action (in_action),
    .state  (in_state),
    .key    (in_key),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      out_block <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_block[8:15], out_block[0:7]};

endmodule

### hdl/aesrs_mix_column.sv
// ----------------------------------------------------------------------------
// AES column mixer
// Forward or inverse MixColumns on one four-byte column.
// ----------------------------------------------------------------------------
module aesrs_mix_column (
  input  logic [0:3][7:0] col_in,
  input  logic            inv,
  output logic [0:3][7:0] col_out
);

  localparam logic [7:0] GF_REDUCE = 8'h1b;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  logic [0:3][7:0] x2;
  logic [0:3][7:0] x4;
  logic [0:3][7:0] x8;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x2[i] = xtime(col_in[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic [1:0] r0;
      logic [1:0] r1;
      logic [1:0] r2;
      logic [1:0] r3;
      r0 = 2'(r);
      r1 = r0 + 2'd1;
      r2 = r0 + 2'd2;
      r3 = r0 + 2'd3;
      if (inv) begin
        // Coefficients 14, 11, 13 and 9 along the row.
        col_out[r] = (x8[r0] ^ x4[r0] ^ x2[r0])
                   ^ (x8[r1] ^ x2[r1] ^ col_in[r1])
                   ^ (x8[r2] ^ x4[r2] ^ col_in[r2])
                   ^ (x8[r3] ^ col_in[r3]);
      end else begin
        col_out[r] = x2[r0] ^ (x2[r1] ^ col_in[r1]) ^ col_in[r2] ^ col_in[r3];
      end
    end
  end

endmodule

### hdl/aesrs_round_logic.sv
// ----------------------------------------------------------------------------
// AES round transformation logic
// Selects one round transformation of the state by action code.
// ----------------------------------------------------------------------------
module aesrs_round_logic (
  input  aesrs_pkg::action_t action,
  input  aesrs_pkg::block_t  state,
  input  aesrs_pkg::block_t  key,
  output aesrs_pkg::block_t  result
);

  aesrs_pkg::block_t sub_fwd;
  aesrs_pkg::block_t sub_inv;
  aesrs_pkg::block_t shift_fwd;
  aesrs_pkg::block_t shift_inv;
  aesrs_pkg::block_t mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub_fwd[i] = aesrs_pkg::SBOX[state[i]];
      sub_inv[i] = aesrs_pkg::RSBOX[state[i]];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [1:0] cf;
        logic [1:0] ci;
        cf = 2'(c) + 2'(r);
        ci = 2'(c) - 2'(r);
        shift_fwd[4 * c + r] = state[{cf, 2'(r)}];
        shift_inv[4 * c + r] = state[{ci, 2'(r)}];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    aesrs_mix_column u_mix (
      .col_in  (state[4 * c +: 4]),
      .inv     (action == aesrs_pkg::ACT_INVMIX),
      .col_out (mixed[4 * c +: 4])
    );
  end

  always_comb begin
    case (action)
      aesrs_pkg::ACT_ADDKEY:   result = state ^ key;
      aesrs_pkg::ACT_SUB:      result = sub_fwd;
      aesrs_pkg::ACT_INVSUB:   result = sub_inv;
      aesrs_pkg::ACT_SHIFT:    result = shift_fwd;
      aesrs_pkg::ACT_INVSHIFT: result = shift_inv;
      aesrs_pkg::ACT_MIX:      result = mixed;
      aesrs_pkg::ACT_INVMIX:   result = mixed;
      default:                 result = state;
    endcase
  end

endmodule

### test/aes_round_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round step comparator
// Watches both stream channels of the round step unit. For every accepted
// request it computes the transformed state from first principles (GF(2^8)
// arithmetic, computed S-boxes, row shifts and column mixing) and checks each
// returned state, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module aes_round_compare (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [255:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  output int           errors,
  output int           outstanding
);

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] GF_TOP    = 8'h80;
  localparam logic [7:0] AFF_CONST = 8'h63;
  localparam logic [7:0] INV_CONST = 8'h05;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } round_out_t;

  round_out_t expected_rounds[$];
  int         fail_total = 0;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    x = a;
    y = b;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) p ^= x;
      if ((x & GF_TOP) != 0) x = (x << 1) ^ GF_POLY;
      else x = x << 1;
      y = y >> 1;
    end
    return p;
  endfunction

  // The multiplicative inverse is a^254; zero maps to zero.
  function automatic logic [7:0] ginv(logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    int         e;
    r = 8'h01;
    base = a;
    e = 254;
    while (e != 0) begin
      if (e & 1) r = gmul(r, base);
      base = gmul(base, base);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] fwd_sub_byte(logic [7:0] v);
    logic [7:0] b;
    b = ginv(v);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ AFF_CONST;
  endfunction

  function automatic logic [7:0] inv_sub_byte(logic [7:0] v);
    return ginv(rol8(v, 1) ^ rol8(v, 3) ^ rol8(v, 6) ^ INV_CONST);
  endfunction

  function automatic aesrs_pkg::block_t mix_columns(aesrs_pkg::block_t st, bit inverse);
    aesrs_pkg::block_t r;
    logic [7:0]        coef [4];
    logic [7:0]        acc;
    if (inverse) begin
      coef[0] = 8'd14; coef[1] = 8'd11; coef[2] = 8'd13; coef[3] = 8'd9;
    end else begin
      coef[0] = 8'd2;  coef[1] = 8'd3;  coef[2] = 8'd1;  coef[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int row = 0; row < 4; row++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gmul(coef[(k - row) & 3], st[4 * c + k]);
        r[4 * c + row] = acc;
      end
    end
    return r;
  endfunction

  function automatic aesrs_pkg::block_t round_step(logic [2:0] act,
                                                   aesrs_pkg::block_t st,
                                                   aesrs_pkg::block_t key);
    aesrs_pkg::block_t r;
    r = st;
    case (act)
      aesrs_pkg::ACT_ADDKEY: r = st ^ key;
      aesrs_pkg::ACT_SUB: begin
        for (int i = 0; i < 16; i++) r[i] = fwd_sub_byte(st[i]);
      end
      aesrs_pkg::ACT_INVSUB: begin
        for (int i = 0; i < 16; i++) r[i] = inv_sub_byte(st[i]);
      end
      aesrs_pkg::ACT_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            r[row + 4 * c] = st[row + 4 * ((c + row) & 3)];
      end
      aesrs_pkg::ACT_INVSHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            r[row + 4 * c] = st[row + 4 * ((c - row + 4) & 3)];
      end
      aesrs_pkg::ACT_MIX:    r = mix_columns(st, 1'b0);
      aesrs_pkg::ACT_INVMIX: r = mix_columns(st, 1'b1);
      default:               r = st;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    aesrs_pkg::block_t st;
    aesrs_pkg::block_t key;
    aesrs_pkg::block_t res;
    round_out_t        want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        st  = {s_tdata[63:0], s_tdata[127:64]};
        key = {s_tdata[191:128], s_tdata[255:192]};
        res = round_step(s_tuser, st, key);
        want.hi = res[0:7];
        want.lo = res[8:15];
        expected_rounds.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (expected_rounds.size() == 0) begin
          $display("%0t: result with no request pending, actual %h", $time, m_tdata);
          fail_total++;
        end else begin
          want = expected_rounds.pop_front();
          if (m_tdata[63:0] !== want.hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, want.hi, m_tdata[63:0]);
            fail_total++;
          end
          if (m_tdata[127:64] !== want.lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, want.lo,
                     m_tdata[127:64]);
            fail_total++;
          end
        end
      end
    end
    errors      <= fail_total;
    outstanding <= expected_rounds.size();
  end

endmodule

### test/tb_aes_round_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round step unit testbench
// Sends a directed set of states for every action code, then random requests
// in bursts against a receiver that stalls in changing patterns. The comparator
// beside the unit predicts and checks every returned state.
// ----------------------------------------------------------------------------
module tb_aes_round_step_unit;

  localparam logic [2:0]  ACT_PASS        = 3'd7;
  localparam int          RANDOM_REQUESTS = 1900;
  localparam logic [63:0] ONES            = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] IDX_HI          = 64'h0001_0203_0405_0607;
  localparam logic [63:0] IDX_LO          = 64'h0809_0a0b_0c0d_0e0f;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;  // state_hi, state_lo, key_hi, key_lo
  logic [2:0]   s_axis_tuser = '0;  // action
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // result_hi, result_lo
  int           errors;
  int           outstanding;
  int           burst_left = 0;
  int           stall_left = 0;
  int           stall_mode = 0;
  int           stall_phase = 0;

  always #4 clk = ~clk;

  aes_round_step_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  aes_round_compare u_compare (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // The receiver switches between always ready, mostly ready, mostly stalled
  // and a fixed one-in-three pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_phase % 3 == 0);
    endcase
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return ONES;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Ends the current burst with a random gap once its length is used up.
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_round(input logic [2:0] act, input logic [63:0] shi, input logic [63:0] slo,
                            input logic [63:0] khi, input logic [63:0] klo);
    sender_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {klo, khi, slo, shi};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] act;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = 30;

    // Every action, including the unused code, on zero, all-ones and indexed
    // states; keys are nonzero where they must be ignored.
    for (int a = 0; a < 8; a++) begin
      act = 3'(a);
      send_round(act, 64'h0, 64'h0, ONES, ONES);
      send_round(act, ONES, ONES, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_round(act, IDX_HI, IDX_LO, 64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      act = 3'($urandom_range(aesrs_pkg::ACT_ADDKEY, ACT_PASS));
      send_round(act, rand_word(), rand_word(), rand_word(), rand_word());
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("aes_round_step_unit: match");
    end else begin
      $display("aes_round_step_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("aes_round_step_unit: mismatch");
    $finish;
  end

endmodule
